>>> hdl/ibs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibs_pkg
// Shared types and constants of the I2C master bit sequencer: the input and
// result words and the classified word passed from the front to the executor.
// ----------------------------------------------------------------------------
package ibs_pkg;

    // input word as it arrives on the push side
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_in;
    } t_in_item;

    // result word, line levels and status after one item
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] received_byte;
        logic       ack_failed;
    } t_out_item;

    // raw action codes
    localparam logic [2:0] ACT_START = 3'd0;
    localparam logic [2:0] ACT_STOP  = 3'd1;
    localparam logic [2:0] ACT_WRITE = 3'd2;
    localparam logic [2:0] ACT_READ  = 3'd3;
    localparam logic [2:0] ACT_WAIT  = 3'd4;

    // item classes after decode
    typedef enum logic [2:0] {
        K_START,
        K_STOP,
        K_WRITE,
        K_READ,
        K_WAIT,
        K_TICK
    } t_kind;

    // classified word handed to the executor
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_in;
    } t_cls;

    localparam logic [7:0] ACK_LIMIT_RST = 8'd250;

endpackage

>>> hdl/i2c_master_bit_sequencer_top.sv
`timescale 1ns / 1ps
// Every word pushed in, command or tick, yields exactly one result word. The
// sequencer takes one word per clock: each word is a single step of the line
// state machine in the executor, so the block sustains one word per cycle
// while pop keeps up. A pushed word is registered in the input queue, then
// passes through the executor, whose result word is registered in the result
// queue, from which it is popped. Both sides have two-entry queues, so push
// and pop may stall independently. The timeout register is written through
// the cfg channel, which is always ready; write it only while no word is in flight.
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_top
// I2C master bit sequencer: input queue and decode, line sequencer, result
// queue.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  ibs_pkg::t_in_item  i_in_word,
    output logic               empty,
    input  logic               pop,
    output ibs_pkg::t_out_item o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);
    import ibs_pkg::*;

    logic      cls_valid;
    t_cls      cls_item;
    logic      cls_take;
    logic      res_valid;
    t_out_item res_item;
    logic      res_full;

    assign o_cfg_ready = 1'b1;

    // decode and input queue
    ibs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .i_word  (i_in_word),
        .full    (full),
        .o_valid (cls_valid),
        .o_item  (cls_item),
        .i_take  (cls_take)
    );

    // line sequencer
    ibs_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (cls_valid),
        .i_item      (cls_item),
        .o_take      (cls_take),
        .o_res_valid (res_valid),
        .o_res       (res_item),
        .i_res_full  (res_full)
    );

    // result queue
    ibs_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res_item),
        .o_full  (res_full),
        .empty   (empty),
        .o_word  (o_out_word),
        .pop     (pop)
    );

endmodule

>>> hdl/ibs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibs_front
// Accepts input words, classifies the action code and holds the classified
// words in a two-entry queue toward the executor.
// ----------------------------------------------------------------------------
module ibs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    input  ibs_pkg::t_in_item i_word,
    output logic            full,
    output logic            o_valid,
    output ibs_pkg::t_cls   o_item,
    input  logic            i_take
);
    import ibs_pkg::*;

    t_cls       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cls       n_cls;
    logic       push_ok, pop_ok;

    // classify: unused codes six and seven behave as ticks
    always_comb begin
        n_cls.data_byte = i_word.data_byte;
        n_cls.send_ack  = i_word.send_ack;
        n_cls.sda_in    = i_word.sda_in;
        unique case (i_word.action)
            ACT_START: n_cls.kind = K_START;
            ACT_STOP:  n_cls.kind = K_STOP;
            ACT_WRITE: n_cls.kind = K_WRITE;
            ACT_READ:  n_cls.kind = K_READ;
            ACT_WAIT:  n_cls.kind = K_WAIT;
            default:   n_cls.kind = K_TICK;
        endcase
    end

    assign full    = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign push_ok = push & ~full;
    assign pop_ok  = o_valid & i_take;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= n_cls;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) r_wp <= ~r_wp;
            if (pop_ok)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push_ok} - {1'b0, pop_ok};
        end
    end

endmodule

>>> hdl/ibs_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibs_exec
// Line sequencer: one step of the SCL/SDA state machine per classified word,
// producing one result word per step. Holds the ACK timeout register.
// ----------------------------------------------------------------------------
module ibs_exec (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_valid,
    input  ibs_pkg::t_cls    i_item,
    output logic             o_take,
    output logic             o_res_valid,
    output ibs_pkg::t_out_item o_res,
    input  logic             i_res_full
);
    import ibs_pkg::*;

    // sequencer phases
    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_ST_A = 4'd1;
    localparam logic [3:0] PH_ST_B = 4'd2;
    localparam logic [3:0] PH_SP_A = 4'd3;
    localparam logic [3:0] PH_SP_B = 4'd4;
    localparam logic [3:0] PH_WA_A = 4'd5;
    localparam logic [3:0] PH_WA_B = 4'd6;
    localparam logic [3:0] PH_POLL = 4'd7;
    localparam logic [3:0] PH_WR_D = 4'd8;
    localparam logic [3:0] PH_WR_H = 4'd9;
    localparam logic [3:0] PH_WR_L = 4'd10;
    localparam logic [3:0] PH_RD_L = 4'd11;
    localparam logic [3:0] PH_RD_H = 4'd12;
    localparam logic [3:0] PH_AK_L = 4'd13;
    localparam logic [3:0] PH_AK_H = 4'd14;

    logic [7:0] r_limit;
    logic [3:0] r_phase, n_phase;
    logic [2:0] r_hold,  n_hold;
    logic [7:0] r_shift, n_shift;
    logic [3:0] r_bidx,  n_bidx;
    logic [7:0] r_poll,  n_poll;
    logic       r_scl,   n_scl;
    logic       r_sda,   n_sda;
    logic       r_drv,   n_drv;
    logic       r_ackc,  n_ackc;
    logic [7:0] r_rx,    n_rx;
    logic       r_fail,  n_fail;
    logic       n_done;
    logic       step;

    assign o_take = ~i_res_full;
    assign step   = i_valid & ~i_res_full;

    // next state for one word
    always_comb begin
        n_phase = r_phase;
        n_hold  = r_hold;
        n_shift = r_shift;
        n_bidx  = r_bidx;
        n_poll  = r_poll;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_drv   = r_drv;
        n_ackc  = r_ackc;
        n_rx    = r_rx;
        n_fail  = r_fail;
        n_done  = 1'b0;
        if (i_item.kind != K_TICK) begin
            // commands only start from idle
            if (r_phase == PH_IDLE) begin
                n_fail = 1'b0;
                unique case (i_item.kind)
                    K_START: begin
                        n_drv = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
                        n_phase = PH_ST_A; n_hold = 3'd4;
                    end
                    K_STOP: begin
                        n_drv = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
                        n_phase = PH_SP_A; n_hold = 3'd4;
                    end
                    K_WRITE: begin
                        n_shift = i_item.data_byte; n_bidx = 4'd0;
                        n_drv = 1'b1; n_scl = 1'b0; n_sda = i_item.data_byte[7];
                        n_phase = PH_WR_D; n_hold = 3'd2;
                    end
                    K_READ: begin
                        n_shift = 8'd0; n_bidx = 4'd0; n_ackc = i_item.send_ack;
                        n_drv = 1'b0; n_scl = 1'b0;
                        n_phase = PH_RD_L; n_hold = 3'd2;
                    end
                    default: begin
                        n_drv = 1'b0; n_sda = 1'b1;
                        n_phase = PH_WA_A; n_hold = 3'd1;
                    end
                endcase
            end
        end else if (r_phase == PH_POLL) begin
            // ACK poll, one sample per tick
            if (!i_item.sda_in) begin
                n_scl = 1'b0;
                n_phase = PH_IDLE; n_hold = 3'd0; n_done = 1'b1;
            end else if (r_poll >= r_limit) begin
                n_fail = 1'b1;
                n_drv = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
                n_phase = PH_SP_A; n_hold = 3'd4;
            end else begin
                n_poll = r_poll + 8'd1;
            end
        end else if (r_phase != PH_IDLE) begin
            if (r_hold > 3'd1) begin
                n_hold = r_hold - 3'd1;
            end else begin
                unique case (r_phase)
                    PH_ST_A: begin n_sda = 1'b0; n_phase = PH_ST_B; n_hold = 3'd4; end
                    PH_ST_B: begin
                        n_scl = 1'b0;
                        n_phase = PH_IDLE; n_hold = 3'd0; n_done = 1'b1;
                    end
                    PH_SP_A: begin
                        n_scl = 1'b1; n_sda = 1'b1;
                        n_phase = PH_SP_B; n_hold = 3'd4;
                    end
                    PH_SP_B: begin n_phase = PH_IDLE; n_hold = 3'd0; n_done = 1'b1; end
                    PH_WA_A: begin n_scl = 1'b1; n_phase = PH_WA_B; n_hold = 3'd1; end
                    PH_WA_B: begin n_poll = 8'd0; n_phase = PH_POLL; n_hold = 3'd0; end
                    PH_WR_D: begin n_scl = 1'b1; n_phase = PH_WR_H; n_hold = 3'd2; end
                    PH_WR_H: begin n_scl = 1'b0; n_phase = PH_WR_L; n_hold = 3'd2; end
                    PH_WR_L: begin
                        n_bidx = r_bidx + 4'd1;
                        if (n_bidx >= 4'd8) begin
                            n_phase = PH_IDLE; n_hold = 3'd0; n_done = 1'b1;
                        end else begin
                            n_sda = r_shift[3'd7 - n_bidx[2:0]];
                            n_phase = PH_WR_D; n_hold = 3'd2;
                        end
                    end
                    PH_RD_L: begin n_scl = 1'b1; n_phase = PH_RD_H; n_hold = 3'd1; end
                    PH_RD_H: begin
                        // sample at the end of the SCL high phase
                        n_shift = {r_shift[6:0], i_item.sda_in};
                        n_bidx  = r_bidx + 4'd1;
                        n_scl   = 1'b0;
                        if (n_bidx >= 4'd8) begin
                            n_drv = 1'b1; n_sda = ~r_ackc;
                            n_phase = PH_AK_L; n_hold = 3'd2;
                        end else begin
                            n_phase = PH_RD_L; n_hold = 3'd2;
                        end
                    end
                    PH_AK_L: begin n_scl = 1'b1; n_phase = PH_AK_H; n_hold = 3'd2; end
                    PH_AK_H: begin
                        n_scl = 1'b0; n_rx = r_shift;
                        n_phase = PH_IDLE; n_hold = 3'd0; n_done = 1'b1;
                    end
                    default: begin n_phase = PH_IDLE; n_hold = 3'd0; end
                endcase
            end
        end
    end

    // result word for this step
    always_comb begin
        o_res_valid            = step;
        o_res.scl_level        = n_scl;
        o_res.sda_level        = n_sda;
        o_res.sda_drive_enable = n_drv;
        o_res.busy_res         = (n_phase != PH_IDLE);
        o_res.done_res         = n_done;
        o_res.received_byte    = n_rx;
        o_res.ack_failed       = n_fail;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= ACK_LIMIT_RST;
            r_phase <= PH_IDLE;
            r_hold  <= 3'd0;
            r_shift <= 8'd0;
            r_bidx  <= 4'd0;
            r_poll  <= 8'd0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_drv   <= 1'b1;
            r_ackc  <= 1'b0;
            r_rx    <= 8'd0;
            r_fail  <= 1'b0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_data;
            if (step) begin
                r_phase <= n_phase;
                r_hold  <= n_hold;
                r_shift <= n_shift;
                r_bidx  <= n_bidx;
                r_poll  <= n_poll;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
                r_drv   <= n_drv;
                r_ackc  <= n_ackc;
                r_rx    <= n_rx;
                r_fail  <= n_fail;
            end
        end
    end

endmodule

>>> hdl/ibs_resq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibs_resq
// Two-entry result queue between the executor and the pop side.
// ----------------------------------------------------------------------------
module ibs_resq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  ibs_pkg::t_out_item i_res,
    output logic               o_full,
    output logic               empty,
    output ibs_pkg::t_out_item o_word,
    input  logic               pop
);
    import ibs_pkg::*;

    t_out_item  r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push_ok, pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign empty   = (r_cnt == 2'd0);
    assign o_word  = r_mem[r_rp];
    assign push_ok = i_valid & ~o_full;
    assign pop_ok  = pop & ~empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_res;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) r_wp <= ~r_wp;
            if (pop_ok)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push_ok} - {1'b0, pop_ok};
        end
    end

endmodule

>>> tb/sv/ibs_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibs_line_checker
// Watches the push, pop and cfg channels of the I2C master bit sequencer. It
// keeps its own copy of the line sequencer, predicts the result word of every
// accepted input word and compares each popped word with the oldest one due.
// ----------------------------------------------------------------------------
module ibs_line_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  ibs_pkg::t_in_item  i_in_word,
    input  logic               i_empty,
    input  logic               i_pop,
    input  ibs_pkg::t_out_item i_out_word,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [7:0]         i_cfg_data,
    output int                 o_fail_count,
    output int                 o_words_waiting
);
    import ibs_pkg::*;

    // line sequencer phases
    typedef enum logic [3:0] {
        LN_IDLE,
        LN_START_A,
        LN_START_B,
        LN_STOP_A,
        LN_STOP_B,
        LN_WAIT_A,
        LN_WAIT_B,
        LN_POLL,
        LN_WR_DATA,
        LN_WR_HIGH,
        LN_WR_LOW,
        LN_RD_LOW,
        LN_RD_HIGH,
        LN_ACK_LOW,
        LN_ACK_HIGH
    } t_line_phase;

    // predicted sequencer state
    t_line_phase phase;
    logic [2:0]  hold;
    logic [7:0]  shift_q;
    logic [3:0]  bit_idx;
    logic [7:0]  poll_cnt;
    logic        scl_q;
    logic        sda_q;
    logic        drv_q;
    logic        ack_sel;
    logic [7:0]  rx_q;
    logic        failed_q;
    logic        done_q;
    logic [7:0]  ack_limit;

    t_out_item   pending_levels[$];
    int          mismatch_count = 0;

    task automatic enter_phase(input t_line_phase ph, input logic [2:0] h);
        phase = ph;
        hold  = h;
    endtask

    task automatic end_command();
        phase  = LN_IDLE;
        hold   = 3'd0;
        done_q = 1'b1;
    endtask

    // stop pattern: both lines low, then both high
    task automatic start_stop_seq();
        drv_q = 1'b1;
        scl_q = 1'b0;
        sda_q = 1'b0;
        enter_phase(LN_STOP_A, 3'd4);
    endtask

    // one input word through the sequencer, returns the line levels after it
    task automatic predict_word(input t_in_item w, output t_out_item r);
        done_q = 1'b0;
        if (w.action <= ACT_WAIT) begin
            // commands are taken only while idle
            if (phase == LN_IDLE) begin
                failed_q = 1'b0;
                case (w.action)
                    ACT_START: begin
                        drv_q = 1'b1;
                        sda_q = 1'b1;
                        scl_q = 1'b1;
                        enter_phase(LN_START_A, 3'd4);
                    end
                    ACT_STOP: begin
                        start_stop_seq();
                    end
                    ACT_WRITE: begin
                        shift_q = w.data_byte;
                        bit_idx = 4'd0;
                        drv_q   = 1'b1;
                        scl_q   = 1'b0;
                        sda_q   = w.data_byte[7];
                        enter_phase(LN_WR_DATA, 3'd2);
                    end
                    ACT_READ: begin
                        shift_q = 8'd0;
                        bit_idx = 4'd0;
                        ack_sel = w.send_ack;
                        drv_q   = 1'b0;
                        scl_q   = 1'b0;
                        enter_phase(LN_RD_LOW, 3'd2);
                    end
                    default: begin
                        drv_q = 1'b0;
                        sda_q = 1'b1;
                        enter_phase(LN_WAIT_A, 3'd1);
                    end
                endcase
            end
        end else if (phase == LN_POLL) begin
            // ACK wait: low SDA is the ACK, too many high polls time out
            if (!w.sda_in) begin
                scl_q = 1'b0;
                end_command();
            end else if (poll_cnt >= ack_limit) begin
                failed_q = 1'b1;
                start_stop_seq();
            end else begin
                poll_cnt = poll_cnt + 8'd1;
            end
        end else if (phase != LN_IDLE) begin
            if (hold > 3'd1) begin
                hold = hold - 3'd1;
            end else begin
                case (phase)
                    LN_START_A: begin
                        sda_q = 1'b0;
                        enter_phase(LN_START_B, 3'd4);
                    end
                    LN_START_B: begin
                        scl_q = 1'b0;
                        end_command();
                    end
                    LN_STOP_A: begin
                        scl_q = 1'b1;
                        sda_q = 1'b1;
                        enter_phase(LN_STOP_B, 3'd4);
                    end
                    LN_STOP_B: end_command();
                    LN_WAIT_A: begin
                        scl_q = 1'b1;
                        enter_phase(LN_WAIT_B, 3'd1);
                    end
                    LN_WAIT_B: begin
                        poll_cnt = 8'd0;
                        enter_phase(LN_POLL, 3'd0);
                    end
                    LN_WR_DATA: begin
                        scl_q = 1'b1;
                        enter_phase(LN_WR_HIGH, 3'd2);
                    end
                    LN_WR_HIGH: begin
                        scl_q = 1'b0;
                        enter_phase(LN_WR_LOW, 3'd2);
                    end
                    LN_WR_LOW: begin
                        bit_idx = bit_idx + 4'd1;
                        if (bit_idx >= 4'd8) begin
                            end_command();
                        end else begin
                            // MSB first
                            sda_q = shift_q[~bit_idx[2:0]];
                            enter_phase(LN_WR_DATA, 3'd2);
                        end
                    end
                    LN_RD_LOW: begin
                        scl_q = 1'b1;
                        enter_phase(LN_RD_HIGH, 3'd1);
                    end
                    LN_RD_HIGH: begin
                        // sample on the tick that ends SCL high
                        shift_q = {shift_q[6:0], w.sda_in};
                        bit_idx = bit_idx + 4'd1;
                        scl_q   = 1'b0;
                        if (bit_idx >= 4'd8) begin
                            drv_q = 1'b1;
                            sda_q = ~ack_sel;
                            enter_phase(LN_ACK_LOW, 3'd2);
                        end else begin
                            enter_phase(LN_RD_LOW, 3'd2);
                        end
                    end
                    LN_ACK_LOW: begin
                        scl_q = 1'b1;
                        enter_phase(LN_ACK_HIGH, 3'd2);
                    end
                    LN_ACK_HIGH: begin
                        scl_q = 1'b0;
                        rx_q  = shift_q;
                        end_command();
                    end
                    default: enter_phase(LN_IDLE, 3'd0);
                endcase
            end
        end

        r.scl_level        = scl_q;
        r.sda_level        = sda_q;
        r.sda_drive_enable = drv_q;
        r.busy_res         = (phase != LN_IDLE);
        r.done_res         = done_q;
        r.received_byte    = rx_q;
        r.ack_failed       = failed_q;
    endtask

    // channel monitor: config, compare on pop, predict on push
    always @(posedge i_clk) begin : watch
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            phase     = LN_IDLE;
            hold      = 3'd0;
            shift_q   = 8'd0;
            bit_idx   = 4'd0;
            poll_cnt  = 8'd0;
            scl_q     = 1'b1;
            sda_q     = 1'b1;
            drv_q     = 1'b1;
            ack_sel   = 1'b0;
            rx_q      = 8'd0;
            failed_q  = 1'b0;
            done_q    = 1'b0;
            ack_limit = ACK_LIMIT_RST;
            pending_levels.delete();
        end else begin
            got = i_out_word;
            if (i_cfg_valid && i_cfg_ready)
                ack_limit = i_cfg_data;
            if (i_pop && !i_empty) begin
                if (pending_levels.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: unexpected result word %h", $time, got);
                    mismatch_count++;
                end else begin
                    want = pending_levels.pop_front();
                    if (got.scl_level !== want.scl_level ||
                        got.sda_level !== want.sda_level ||
                        got.sda_drive_enable !== want.sda_drive_enable ||
                        got.busy_res !== want.busy_res ||
                        got.done_res !== want.done_res ||
                        got.received_byte !== want.received_byte ||
                        got.ack_failed !== want.ack_failed) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: result mismatch (scl sda drv busy done rx fail)",
                                     $time);
                            $display("    expected %b %b %b %b %b %h %b",
                                     want.scl_level, want.sda_level,
                                     want.sda_drive_enable, want.busy_res,
                                     want.done_res, want.received_byte,
                                     want.ack_failed);
                            $display("    actual   %b %b %b %b %b %h %b",
                                     got.scl_level, got.sda_level,
                                     got.sda_drive_enable, got.busy_res,
                                     got.done_res, got.received_byte,
                                     got.ack_failed);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (i_push && !i_full) begin
                predict_word(i_in_word, want);
                pending_levels.push_back(want);
            end
        end
        o_fail_count    <= mismatch_count;
        o_words_waiting <= pending_levels.size();
    end

endmodule

>>> tb/sv/i2c_master_bit_sequencer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_top_tb
// Drives command and tick words into the I2C master bit sequencer: a short
// directed run, then mostly complete command sequences with random content
// plus stray and cut-short ones, across several timeout limits and idle
// patterns on both sides. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_top_tb;
    import ibs_pkg::*;

    // tick codes: five is the tick, six and seven act as ticks too
    localparam logic [2:0] ACT_TICK    = 3'd5;
    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;

    localparam int DRAIN_HOLD_CYCLES = 300;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       push;
    logic       full;
    t_in_item   in_word;
    logic       empty;
    logic       pop;
    t_out_item  out_word;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    int         fail_count;
    int         words_waiting;
    int         send_idle_pct  = 19;
    int         drain_idle_pct = 85;
    int         hold_requests  = 0;
    int         holds_served   = 0;
    int         hold_left      = 0;
    int         seq_items      = 0;
    logic [7:0] cur_limit;

    always #5 i_clk = ~i_clk;

    i2c_master_bit_sequencer_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_word   (in_word),
        .empty       (empty),
        .pop         (pop),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    ibs_line_checker u_line_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_in_word       (in_word),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_out_word      (out_word),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_words_waiting (words_waiting)
    );

    // run limit
    initial begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    // result side: random pop, long hold-off when requested
    initial begin
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && holds_served != hold_requests) begin
                hold_left = DRAIN_HOLD_CYCLES;
                holds_served++;
            end
            if (hold_left != 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99, 0) >= drain_idle_pct);
            end
        end
    end

    // push one word, with random idle cycles ahead of it
    task automatic send_word(input t_in_item w);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        in_word <= w;
        push    <= 1'b1;
        do @(posedge i_clk); while (full);
    endtask

    task automatic send_cmd(input logic [2:0] act, input logic [7:0] data,
                            input logic ack);
        t_in_item w;
        w.action    = act;
        w.data_byte = data;
        w.send_ack  = ack;
        w.sda_in    = 1'($urandom_range(1, 0));
        send_word(w);
        seq_items++;
    endtask

    task automatic send_tick(input logic [2:0] act, input logic sda);
        t_in_item w;
        w.action    = act;
        w.data_byte = 8'($urandom_range(255, 0));
        w.send_ack  = 1'($urandom_range(1, 0));
        w.sda_in    = sda;
        send_word(w);
        seq_items++;
    endtask

    // mostly the plain tick code, now and then a spare one
    function automatic logic [2:0] tick_code();
        case ($urandom_range(9, 0))
            0:       return ACT_SPARE_A;
            1:       return ACT_SPARE_B;
            default: return ACT_TICK;
        endcase
    endfunction

    // ACK wait with a number of high polls; past the limit it times out
    task automatic run_wait_ack(input int polls);
        send_cmd(ACT_WAIT, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
        repeat (2) send_tick(tick_code(), 1'($urandom_range(1, 0)));
        repeat (polls) send_tick(tick_code(), 1'b1);
        if (polls > cur_limit)
            repeat (8) send_tick(tick_code(), 1'($urandom_range(1, 0)));
        else
            send_tick(tick_code(), 1'b0);
    endtask

    // one command with the ticks it needs, sometimes cut short or with noise
    task automatic run_sequence();
        int       pick;
        int       n;
        int       polls;
        t_in_item w;
        pick = $urandom_range(99, 0);
        n    = 0;
        if (pick < 15) begin
            send_cmd(ACT_START, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
            n = 8;
        end else if (pick < 30) begin
            send_cmd(ACT_STOP, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
            n = 8;
        end else if (pick < 55) begin
            send_cmd(ACT_WRITE, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
            n = 48;
        end else if (pick < 80) begin
            send_cmd(ACT_READ, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
            n = 28;
        end else begin
            if (cur_limit <= 8'd16)
                polls = $urandom_range(cur_limit + 1, 0);
            else
                polls = $urandom_range(12, 0);
            run_wait_ack(polls);
        end
        // cut short: the next command lands on a busy block
        if ($urandom_range(99, 0) < 10)
            n = $urandom_range(n, 0);
        repeat (n) send_tick(tick_code(), 1'($urandom_range(1, 0)));
        // stray word of any kind
        if ($urandom_range(99, 0) < 15) begin
            w.action    = 3'($urandom_range(7, 0));
            w.data_byte = 8'($urandom_range(255, 0));
            w.send_ack  = 1'($urandom_range(1, 0));
            w.sda_in    = 1'($urandom_range(1, 0));
            send_word(w);
        end
        repeat ($urandom_range(2, 0)) send_tick(tick_code(), 1'($urandom_range(1, 0)));
    endtask

    task automatic run_random(input int budget);
        int start;
        start = seq_items;
        while (seq_items - start < budget)
            run_sequence();
    endtask

    // stop pushing and wait until every result word has been popped
    task automatic drain_all();
        push <= 1'b0;
        @(posedge i_clk);
        while (words_waiting != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [7:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_limit = v;
    endtask

    initial begin
        push      <= 1'b0;
        in_word   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        i_rst_n   <= 1'b0;
        cur_limit = ACK_LIMIT_RST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle tick, stop from idle, commands while busy, spare codes
        send_tick(ACT_TICK, 1'b0);
        send_cmd(ACT_STOP, 8'hFF, 1'b1);
        send_cmd(ACT_WRITE, 8'h00, 1'b0);
        send_cmd(ACT_READ, 8'hFF, 1'b1);
        send_tick(ACT_SPARE_A, 1'b1);
        send_tick(ACT_SPARE_B, 1'b0);
        repeat (6) send_tick(ACT_TICK, 1'b1);
        // start, then ACK wait answered after one high poll
        send_cmd(ACT_START, 8'h00, 1'b0);
        repeat (8) send_tick(ACT_TICK, 1'b0);
        run_wait_ack(1);
        drain_all();

        // sender idles lightly, receiver heavily; tightest timeout
        set_limit(8'd1);
        run_random(100);
        drain_all();

        // roles swapped; widest timeout, one full timeout first
        send_idle_pct  = 85;
        drain_idle_pct = 19;
        set_limit(8'd255);
        run_wait_ack(256);
        run_random(60);
        drain_all();

        // no idling; receiver holds off while the sender keeps pushing
        send_idle_pct  = 0;
        drain_idle_pct = 0;
        set_limit(8'($urandom_range(16, 2)));
        hold_requests++;
        repeat (3) run_sequence();
        run_random(100);
        drain_all();

        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
